FILE: rtl/svgcs_pkg.sv
package svgcs_pkg;

  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CountWidth = 12;

  localparam logic [CountWidth-1:0] ScanLimitReset = 12'd1024;
  localparam logic [CountWidth-1:0] CountMax       = '1;

  localparam logic [AddrWidth-3:0] RegScanLimit = 1'b0;

  localparam logic [1:0] KindReject   = 2'd0;
  localparam logic [1:0] KindRoot     = 2'd1;
  localparam logic [1:0] KindPrologue = 2'd2;

  localparam logic [7:0] ChBomA = 8'hEF;
  localparam logic [7:0] ChBomB = 8'hBB;
  localparam logic [7:0] ChBomC = 8'hBF;
  localparam logic [7:0] ChLt   = 8'h3C;

  // candidate bits: svg root, xml declaration, comment, doctype
  localparam int unsigned CandSvg     = 0;
  localparam int unsigned CandXml     = 1;
  localparam int unsigned CandComment = 2;
  localparam int unsigned CandDoctype = 3;
  localparam logic [3:0]  CandAll     = 4'hF;

  typedef enum logic [3:0] {
    PH_START,
    PH_BOM1,
    PH_BOM2,
    PH_WS,
    PH_PREFIX,
    PH_DOCWS,
    PH_SCAN,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    V_UNDECIDED,
    V_REJECT,
    V_ROOT,
    V_PROLOGUE
  } verdict_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       is_svg;
    logic [1:0] match_kind;
  } result_t;

  function automatic logic is_ws(logic [7:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
  endfunction

  // which candidates carry lower-case byte c at position p
  function automatic logic [3:0] prefix_hits(logic [3:0] p, logic [7:0] c);
    logic [3:0] hit;
    hit = '0;
    unique case (p)
      4'd0: hit = {4{c == ChLt}};
      4'd1: hit = {c == "!", c == "!", c == "?", c == "s"};
      4'd2: hit = {c == "d", c == "-", c == "x", c == "v"};
      4'd3: hit = {c == "o", c == "-", c == "m", c == "g"};
      4'd4: hit = {c == "c", 1'b0, c == "l", 1'b0};
      4'd5: hit = {c == "t", 3'b000};
      4'd6: hit = {c == "y", 3'b000};
      4'd7: hit = {c == "p", 3'b000};
      4'd8: hit = {c == "e", 3'b000};
      default: hit = '0;
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] doctype_char(logic [1:0] stage);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (stage)
      2'd0: ch = "s";
      2'd1: ch = "v";
      2'd2: ch = "g";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] tag_char(logic [1:0] pos);
    logic [7:0] ch;
    ch = ChLt;
    unique case (pos)
      2'd0: ch = ChLt;
      2'd1: ch = "s";
      2'd2: ch = "v";
      2'd3: ch = "g";
      default: ch = ChLt;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/svgcs_cfg_regs.sv
module svgcs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [svgcs_pkg::AddrWidth-1:0]     paddr,
  input  logic [svgcs_pkg::DataWidth-1:0]     pwdata,
  output logic [svgcs_pkg::DataWidth-1:0]     prdata,
  output logic                                pready,
  output logic [svgcs_pkg::CountWidth-1:0]    scan_limit_o
);

  logic [svgcs_pkg::CountWidth-1:0] scan_limit_q, scan_limit_d;
  logic                             hit_limit;
  logic                             wr_en;

  assign hit_limit = (paddr[svgcs_pkg::AddrWidth-1:2] == svgcs_pkg::RegScanLimit);
  assign wr_en     = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  always_comb begin
    scan_limit_d = scan_limit_q;
    if (wr_en && hit_limit) begin
      scan_limit_d = pwdata[svgcs_pkg::CountWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= svgcs_pkg::ScanLimitReset;
    end else begin
      scan_limit_q <= scan_limit_d;
    end
  end

  assign prdata = hit_limit
                ? {{(svgcs_pkg::DataWidth - svgcs_pkg::CountWidth){1'b0}}, scan_limit_q}
                : '0;

  assign scan_limit_o = scan_limit_q;

endmodule

FILE: rtl/svgcs_match.sv
module svgcs_match (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  svgcs_pkg::item_t                 item_i,
  input  logic [svgcs_pkg::CountWidth-1:0] scan_limit_i,
  output svgcs_pkg::result_t               result_o
);

  svgcs_pkg::phase_e                phase_q, phase_d;
  svgcs_pkg::verdict_e              verdict_q, verdict_d;
  logic [svgcs_pkg::CountWidth-1:0] stripped_q, stripped_d;
  logic [3:0]                       prefix_pos_q, prefix_pos_d;
  logic [3:0]                       cand_q, cand_d;
  logic [1:0]                       doc_stage_q, doc_stage_d;
  logic [1:0]                       tag_pos_q, tag_pos_d;

  always_comb begin
    logic [7:0]        raw;
    logic [7:0]        c;
    logic [3:0]        f;
    svgcs_pkg::phase_e ph;
    raw = item_i.byte_value;
    c   = svgcs_pkg::to_lower(raw);
    f   = cand_q & svgcs_pkg::prefix_hits(prefix_pos_q, c);
    ph  = (phase_q == svgcs_pkg::PH_START) ? svgcs_pkg::PH_WS : phase_q;

    phase_d      = phase_q;
    verdict_d    = verdict_q;
    stripped_d   = stripped_q;
    prefix_pos_d = prefix_pos_q;
    cand_d       = cand_q;
    doc_stage_d  = doc_stage_q;
    tag_pos_d    = tag_pos_q;

    if ((phase_q == svgcs_pkg::PH_START) && (raw == svgcs_pkg::ChBomA)) begin
      phase_d = svgcs_pkg::PH_BOM1;
    end else begin
      phase_d = ph;
      if ((ph == svgcs_pkg::PH_PREFIX) || (ph == svgcs_pkg::PH_DOCWS) ||
          (ph == svgcs_pkg::PH_SCAN)) begin
        if (stripped_q != svgcs_pkg::CountMax) begin
          stripped_d = stripped_q + 1'b1;
        end
      end
      unique case (ph)
        svgcs_pkg::PH_BOM1: begin
          if (raw == svgcs_pkg::ChBomB) begin
            phase_d = svgcs_pkg::PH_BOM2;
          end else begin
            phase_d   = svgcs_pkg::PH_DONE;
            verdict_d = svgcs_pkg::V_REJECT;
          end
        end
        svgcs_pkg::PH_BOM2: begin
          if (raw == svgcs_pkg::ChBomC) begin
            phase_d = svgcs_pkg::PH_WS;
          end else begin
            phase_d   = svgcs_pkg::PH_DONE;
            verdict_d = svgcs_pkg::V_REJECT;
          end
        end
        svgcs_pkg::PH_WS: begin
          if (svgcs_pkg::is_ws(raw)) begin
            phase_d = svgcs_pkg::PH_WS;
          end else if (raw == svgcs_pkg::ChLt) begin
            phase_d      = svgcs_pkg::PH_PREFIX;
            prefix_pos_d = 4'd1;
            cand_d       = svgcs_pkg::CandAll;
            stripped_d   = 12'd1;
          end else begin
            phase_d   = svgcs_pkg::PH_DONE;
            verdict_d = svgcs_pkg::V_REJECT;
          end
        end
        svgcs_pkg::PH_PREFIX: begin
          cand_d = f;
          priority if (f[svgcs_pkg::CandSvg] && (prefix_pos_q == 4'd3)) begin
            phase_d   = svgcs_pkg::PH_DONE;
            verdict_d = svgcs_pkg::V_ROOT;
          end else if ((f[svgcs_pkg::CandXml] && (prefix_pos_q == 4'd4)) ||
                       (f[svgcs_pkg::CandComment] && (prefix_pos_q == 4'd3))) begin
            phase_d   = svgcs_pkg::PH_SCAN;
            tag_pos_d = 2'd0;
          end else if (f[svgcs_pkg::CandDoctype] && (prefix_pos_q == 4'd8)) begin
            phase_d     = svgcs_pkg::PH_DOCWS;
            doc_stage_d = 2'd0;
          end else if (f == 4'd0) begin
            phase_d   = svgcs_pkg::PH_DONE;
            verdict_d = svgcs_pkg::V_REJECT;
          end else begin
            prefix_pos_d = prefix_pos_q + 4'd1;
          end
        end
        svgcs_pkg::PH_DOCWS: begin
          if ((doc_stage_q == 2'd0) && svgcs_pkg::is_ws(c)) begin
            phase_d = svgcs_pkg::PH_DOCWS;
          end else if (c != svgcs_pkg::doctype_char(doc_stage_q)) begin
            phase_d   = svgcs_pkg::PH_DONE;
            verdict_d = svgcs_pkg::V_REJECT;
          end else if (doc_stage_q == 2'd2) begin
            phase_d   = svgcs_pkg::PH_SCAN;
            tag_pos_d = 2'd0;
          end else begin
            doc_stage_d = doc_stage_q + 2'd1;
          end
        end
        svgcs_pkg::PH_SCAN: begin
          if (c == svgcs_pkg::tag_char(tag_pos_q)) begin
            if (tag_pos_q == 2'd3) begin
              if (stripped_q < scan_limit_i) begin
                phase_d   = svgcs_pkg::PH_DONE;
                verdict_d = svgcs_pkg::V_PROLOGUE;
              end else begin
                tag_pos_d = 2'd0;
              end
            end else begin
              tag_pos_d = tag_pos_q + 2'd1;
            end
          end else begin
            tag_pos_d = (c == svgcs_pkg::ChLt) ? 2'd1 : 2'd0;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    unique case (verdict_d)
      svgcs_pkg::V_ROOT: begin
        result_o.is_svg     = 1'b1;
        result_o.match_kind = svgcs_pkg::KindRoot;
      end
      svgcs_pkg::V_PROLOGUE: begin
        result_o.is_svg     = 1'b1;
        result_o.match_kind = svgcs_pkg::KindPrologue;
      end
      default: begin
        result_o.is_svg     = 1'b0;
        result_o.match_kind = svgcs_pkg::KindReject;
      end
    endcase

    // end of buffer: back to the state for a fresh buffer
    if (item_i.last_byte) begin
      phase_d      = svgcs_pkg::PH_START;
      verdict_d    = svgcs_pkg::V_UNDECIDED;
      stripped_d   = '0;
      prefix_pos_d = '0;
      cand_d       = svgcs_pkg::CandAll;
      doc_stage_d  = '0;
      tag_pos_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= svgcs_pkg::PH_START;
      verdict_q    <= svgcs_pkg::V_UNDECIDED;
      stripped_q   <= '0;
      prefix_pos_q <= '0;
      cand_q       <= svgcs_pkg::CandAll;
      doc_stage_q  <= '0;
      tag_pos_q    <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      verdict_q    <= verdict_d;
      stripped_q   <= stripped_d;
      prefix_pos_q <= prefix_pos_d;
      cand_q       <= cand_d;
      doc_stage_q  <= doc_stage_d;
      tag_pos_q    <= tag_pos_d;
    end
  end

endmodule

FILE: rtl/svg_content_sniffer_core.sv
// the verdict for the last byte in the input register is held in the result register
// throughput: one byte per cycle; a last byte waits while a held verdict is pending
// an input register and a result register decouple the two channels
// reset: asynchronous active low; buffer state cleared, scan_limit returns to 1024
module svg_content_sniffer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [svgcs_pkg::AddrWidth-1:0]  paddr,
  input  logic [svgcs_pkg::DataWidth-1:0]  pwdata,
  output logic [svgcs_pkg::DataWidth-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       byte_value_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             is_svg_o,
  output logic [1:0]                       match_kind_o
);

  logic [svgcs_pkg::CountWidth-1:0] scan_limit;
  logic                             in_valid_q, in_valid_d;
  svgcs_pkg::item_t                 item_q;
  logic                             out_valid_q, out_valid_d;
  svgcs_pkg::result_t               result_q, result;
  logic                             out_free;
  logic                             step;
  logic                             in_fire;

  svgcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .scan_limit_o(scan_limit)
  );

  svgcs_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .scan_limit_i(scan_limit),
    .result_o    (result)
  );

  assign out_free   = ~out_valid_q | out_ready_i;
  assign step       = in_valid_q & (~item_q.last_byte | out_free);
  assign in_ready_o = ~in_valid_q | step;
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step && item_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.byte_value <= byte_value_i;
      item_q.last_byte  <= last_byte_i;
    end
    if (step && item_q.last_byte) begin
      result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_svg_o     = result_q.is_svg;
  assign match_kind_o = result_q.match_kind;

endmodule

FILE: rtl/svgcs_checker.sv
module svgcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [svgcs_pkg::AddrWidth-1:0]  paddr,
  input logic [svgcs_pkg::DataWidth-1:0]  pwdata,
  input logic [svgcs_pkg::DataWidth-1:0]  prdata,
  input logic                             pready,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [7:0]                       byte_value_i,
  input logic                             last_byte_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             is_svg_o,
  input logic [1:0]                       match_kind_o
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_svg_o) && $stable(match_kind_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_svg_o == (match_kind_o != svgcs_pkg::KindReject)) &&
                    (match_kind_o != 2'd3))
    else $error("verdict and kind disagree");

  // a fresh verdict follows an accepted last-byte transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i, 2))
    else $error("verdict without a last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr == '0) |=>
      (paddr != '0) ||
      (prdata == {{(svgcs_pkg::DataWidth - svgcs_pkg::CountWidth){1'b0}},
                  $past(pwdata[svgcs_pkg::CountWidth-1:0])}))
    else $error("scan_limit readback mismatch");

endmodule

bind svg_content_sniffer_core svgcs_checker u_svgcs_checker (.*);
